[rtl/csfr_pkg.sv]
`timescale 1ns / 1ps
package csfr_pkg;

  // frame store geometry
  localparam int MAX_FRAME_LEN = 32;
  localparam int POS_W         = $clog2(MAX_FRAME_LEN);
  localparam int CNT_W         = $clog2(MAX_FRAME_LEN + 1);
  localparam int RAM_DEPTH     = 2 * MAX_FRAME_LEN;  // two banks
  localparam int RAM_AW        = $clog2(RAM_DEPTH);

  localparam int BYTE_W   = 8;
  localparam int MINLEN_W = 6;
  localparam int BPOS_W   = 5;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_HEAD     = 2'd0;
  localparam cfg_idx_t REG_MIN_LEN  = 2'd1;
  localparam cfg_idx_t REG_KEY_ADDR = 2'd2;

  localparam logic [MINLEN_W-1:0] MIN_LEN_RST = 6'd4;

  // job queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int QPTR_W  = $clog2(Q_DEPTH);
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  // candidate frame: bank holding it, its length, address matched key
  typedef struct packed {
    logic             bank;
    logic [CNT_W-1:0] len;
    logic             key_hit;
  } job_t;

  // bank handed back from back end to front end
  typedef struct packed {
    logic vld;
    logic bank;
  } rel_t;

endpackage

[rtl/csfr_ram.sv]
`timescale 1ns / 1ps
module csfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/csfr_front.sv]
`timescale 1ns / 1ps
module csfr_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [csfr_pkg::BYTE_W-1:0]     in_rx_byte,
  input  logic [csfr_pkg::BYTE_W-1:0]     head_byte,
  input  logic [csfr_pkg::MINLEN_W-1:0]   min_length,
  input  logic [csfr_pkg::BYTE_W-1:0]     key_address,
  output logic                            wr_en,
  output logic [csfr_pkg::RAM_AW-1:0]     wr_addr,
  output logic [csfr_pkg::BYTE_W-1:0]     wr_data,
  output logic                            push,
  output csfr_pkg::job_t                  push_job,
  input  csfr_pkg::rel_t                  rel
);
  import csfr_pkg::*;

  localparam logic [POS_W-1:0] POS_ADDR = POS_W'(1);
  localparam logic [POS_W-1:0] POS_LEN  = POS_W'(2);

  logic              active_r, active_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [BYTE_W-1:0] len_r, len_nxt;
  logic [BYTE_W-1:0] addr_r, addr_nxt;
  logic              wbank_r, wbank_nxt;
  logic [1:0]        busy_r, busy_nxt;

  logic              accept;
  logic [POS_W-1:0]  wr_pos;
  logic              frame_done;
  logic [BYTE_W-1:0] min_ext;

  assign in_stall = busy_r[wbank_r];
  assign accept   = in_valid && !in_stall;
  assign min_ext  = BYTE_W'(min_length);
  assign wr_addr  = {wbank_r, wr_pos};
  assign wr_data  = in_rx_byte;

  always_comb begin
    active_nxt = active_r;
    count_nxt  = count_r;
    len_nxt    = len_r;
    addr_nxt   = addr_r;
    wbank_nxt  = wbank_r;
    wr_en      = 1'b0;
    wr_pos     = '0;
    push       = 1'b0;
    push_job   = '0;
    frame_done = 1'b0;
    if (accept) begin
      if (in_rx_byte == head_byte && !active_r) begin
        active_nxt = 1'b1;
        count_nxt  = CNT_W'(1);
        len_nxt    = min_ext;
        wr_en      = 1'b1;
      end else if (count_r == CNT_W'(2)) begin
        wr_en     = 1'b1;
        wr_pos    = POS_LEN;
        count_nxt = CNT_W'(3);
        len_nxt   = in_rx_byte;
        if (in_rx_byte > BYTE_W'(MAX_FRAME_LEN) || in_rx_byte < min_ext) begin
          len_nxt    = min_ext;
          count_nxt  = '0;
          active_nxt = 1'b0;
        end
      end else if (active_r && count_r < CNT_W'(MAX_FRAME_LEN)) begin
        wr_en     = 1'b1;
        wr_pos    = count_r[POS_W-1:0];
        count_nxt = count_r + CNT_W'(1);
        if (count_r[POS_W-1:0] == POS_ADDR) begin
          addr_nxt = in_rx_byte;
        end
      end

      frame_done = (count_nxt >= CNT_W'(MAX_FRAME_LEN) || BYTE_W'(count_nxt) >= len_nxt)
                   && BYTE_W'(count_nxt) > min_ext;
      if (frame_done) begin
        // length must address a real entry; checksum is judged downstream
        if (len_nxt != '0 && len_nxt <= BYTE_W'(MAX_FRAME_LEN)) begin
          push             = 1'b1;
          push_job.bank    = wbank_r;
          push_job.len     = CNT_W'(len_nxt);
          push_job.key_hit = (addr_nxt == key_address);
          wbank_nxt        = ~wbank_r;
        end
        count_nxt  = '0;
        active_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    if (push) begin
      busy_nxt[wbank_r] = 1'b1;
    end
    if (rel.vld) begin
      busy_nxt[rel.bank] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      count_r  <= '0;
      wbank_r  <= 1'b0;
      busy_r   <= '0;
    end else begin
      active_r <= active_nxt;
      count_r  <= count_nxt;
      wbank_r  <= wbank_nxt;
      busy_r   <= busy_nxt;
    end
  end

  // len_r mirrors store entry 2, addr_r store entry 1
  always_ff @(posedge clk) begin
    len_r  <= len_nxt;
    addr_r <= addr_nxt;
  end

`ifndef NO_ASSERTIONS
  a_push_free_bank: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !busy_r[wbank_r])
    else $error("frame pushed into a bank still held by the back end");

  a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
    !active_r |-> count_r == '0)
    else $error("byte count left non-zero outside a frame");
`endif

endmodule

[rtl/csfr_queue.sv]
`timescale 1ns / 1ps
module csfr_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  csfr_pkg::job_t push_job,
  input  logic           pop,
  output logic           q_valid,
  output csfr_pkg::job_t head_job
);
  import csfr_pkg::*;

  job_t              q_mem_r [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              full;

  assign q_valid  = cnt_r != '0;
  assign full     = cnt_r == QCNT_W'(Q_DEPTH);
  assign head_job = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= push_job;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("job queue overflow");
`endif

endmodule

[rtl/csfr_back.sv]
`timescale 1ns / 1ps
module csfr_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  csfr_pkg::job_t                head_job,
  output logic                          pop,
  output logic                          rd_en,
  output logic [csfr_pkg::RAM_AW-1:0]   rd_addr,
  input  logic [csfr_pkg::BYTE_W-1:0]   rd_data,
  output csfr_pkg::rel_t                rel,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [csfr_pkg::BYTE_W-1:0]   out_frame_byte,
  output logic [csfr_pkg::BPOS_W-1:0]   out_byte_pos,
  output logic                          out_last,
  output logic                          out_key_pressed
);
  import csfr_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SUM  = 4'b0010,
    ST_RD   = 4'b0100,
    ST_LD   = 4'b1000
  } back_state_t;

  back_state_t       state_r, state_nxt;
  job_t              job_r, job_nxt;
  logic [CNT_W-1:0]  iss_r, iss_nxt;
  logic              dvalid_r, dvalid_nxt;
  logic [POS_W-1:0]  dpos_r, dpos_nxt;
  logic [BYTE_W-1:0] sum_r, sum_nxt;
  logic [POS_W-1:0]  idx_r, idx_nxt;
  logic              key_flag_r, key_flag_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic [BPOS_W-1:0] out_pos_r, out_pos_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_key_r, out_key_nxt;

  logic [CNT_W-1:0]  len_m1;
  logic [POS_W-1:0]  last_pos;
  logic [POS_W-1:0]  rd_pos;
  logic              slot_free;

  assign len_m1    = job_r.len - CNT_W'(1);
  assign last_pos  = len_m1[POS_W-1:0];
  assign slot_free = !out_valid_r || !out_stall;
  assign rd_addr   = {job_r.bank, rd_pos};

  always_comb begin
    state_nxt     = state_r;
    job_nxt       = job_r;
    iss_nxt       = iss_r;
    dvalid_nxt    = 1'b0;
    dpos_nxt      = dpos_r;
    sum_nxt       = sum_r;
    idx_nxt       = idx_r;
    key_flag_nxt  = key_flag_r;
    pop           = 1'b0;
    rd_en         = 1'b0;
    rd_pos        = '0;
    rel           = '0;
    out_valid_nxt = out_valid_r && out_stall;
    out_byte_nxt  = out_byte_r;
    out_pos_nxt   = out_pos_r;
    out_last_nxt  = out_last_r;
    out_key_nxt   = out_key_r;

    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          pop       = 1'b1;
          job_nxt   = head_job;
          iss_nxt   = '0;
          sum_nxt   = '0;
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        // stream the frame through the adder, one entry a cycle; the last entry is the checksum compared
        if (iss_r < job_r.len) begin
          rd_en      = 1'b1;
          rd_pos     = iss_r[POS_W-1:0];
          iss_nxt    = iss_r + CNT_W'(1);
          dvalid_nxt = 1'b1;
          dpos_nxt   = iss_r[POS_W-1:0];
        end
        if (dvalid_r) begin
          if (dpos_r == last_pos) begin
            if (sum_r == rd_data) begin
              key_flag_nxt = key_flag_r | job_r.key_hit;
              idx_nxt      = '0;
              state_nxt    = ST_RD;
            end else begin
              rel.vld   = 1'b1;
              rel.bank  = job_r.bank;
              state_nxt = ST_IDLE;
            end
          end else begin
            sum_nxt = sum_r + rd_data;
          end
        end
      end
      ST_RD: begin
        rd_en     = 1'b1;
        rd_pos    = idx_r;
        state_nxt = ST_LD;
      end
      ST_LD: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = rd_data;
          out_pos_nxt   = BPOS_W'(idx_r);
          out_last_nxt  = (idx_r == last_pos);
          out_key_nxt   = key_flag_r;
          if (idx_r == last_pos) begin
            rel.vld   = 1'b1;
            rel.bank  = job_r.bank;
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt   = idx_r + POS_W'(1);
            state_nxt = ST_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      dvalid_r    <= 1'b0;
      key_flag_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dvalid_r    <= dvalid_nxt;
      key_flag_r  <= key_flag_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r      <= job_nxt;
    iss_r      <= iss_nxt;
    dpos_r     <= dpos_nxt;
    sum_r      <= sum_nxt;
    idx_r      <= idx_nxt;
    out_byte_r <= out_byte_nxt;
    out_pos_r  <= out_pos_nxt;
    out_last_r <= out_last_nxt;
    out_key_r  <= out_key_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_frame_byte  = out_byte_r;
  assign out_byte_pos    = out_pos_r;
  assign out_last        = out_last_r;
  assign out_key_pressed = out_key_r;

`ifndef NO_ASSERTIONS
  a_rel_ends_job: assert property (@(posedge clk) disable iff (!rst_n)
    rel.vld |=> state_r == ST_IDLE)
    else $error("bank released while the job carries on");
`endif

endmodule

[rtl/checksum_frame_receiver.sv]
`timescale 1ns / 1ps
// Path: once its closing byte is taken, a good frame passes the queue hop, the
//   checksum pass, a store read and the load before its first beat is presented.
// Throughput: one input beat a cycle while a free store bank exists; replay
//   does a store read, then the output load, per output beat; out_stall holds the load.
// Reset: rst_n synchronous, active low; resets configuration, clears control
//   state. The frame store is not cleared: entries are read only once written.
module checksum_frame_receiver (
  input  logic                          clk,
  input  logic                          rst_n,
  // received bytes
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [csfr_pkg::BYTE_W-1:0]   in_rx_byte,
  // accepted frame, one beat per byte
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [csfr_pkg::BYTE_W-1:0]   out_frame_byte,
  output logic [csfr_pkg::BPOS_W-1:0]   out_byte_pos,
  output logic                          out_last,
  output logic                          out_key_pressed,
  // register writes
  input  logic                          cfg_wr_en,
  input  logic [csfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [csfr_pkg::BYTE_W-1:0]   cfg_wdata
);
  import csfr_pkg::*;

  // configuration registers
  logic [BYTE_W-1:0]   head_r;
  logic [MINLEN_W-1:0] min_len_r;
  logic [BYTE_W-1:0]   key_addr_r;

  // front end store writes, back end store reads
  logic              wr_en;
  logic [RAM_AW-1:0] wr_addr;
  logic [BYTE_W-1:0] wr_data;
  logic              rd_en;
  logic [RAM_AW-1:0] rd_addr;
  logic [BYTE_W-1:0] rd_data;

  // job hand-over
  logic push;
  job_t push_job;
  logic pop;
  logic q_valid;
  job_t head_job;
  rel_t rel;

  // writes to an unlisted index are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r     <= '0;
      min_len_r  <= MIN_LEN_RST;
      key_addr_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_HEAD:     head_r     <= cfg_wdata;
        REG_MIN_LEN:  min_len_r  <= cfg_wdata[MINLEN_W-1:0];
        REG_KEY_ADDR: key_addr_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // front: hunts for the head, checks the length, fills one of two banks
  csfr_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_rx_byte  (in_rx_byte),
    .head_byte   (head_r),
    .min_length  (min_len_r),
    .key_address (key_addr_r),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .push        (push),
    .push_job    (push_job),
    .rel         (rel)
  );

  // frame store: bank select in the top address bit
  csfr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RAM_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // completed frames awaiting the checksum pass
  csfr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .q_valid  (q_valid),
    .head_job (head_job)
  );

  // back: verifies the sum, updates the key flag, replays good frames
  csfr_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .head_job        (head_job),
    .pop             (pop),
    .rd_en           (rd_en),
    .rd_addr         (rd_addr),
    .rd_data         (rd_data),
    .rel             (rel),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_frame_byte  (out_frame_byte),
    .out_byte_pos    (out_byte_pos),
    .out_last        (out_last),
    .out_key_pressed (out_key_pressed)
  );

endmodule
